>>> rtl/cctb_pkg.sv
// ----------------------------------------------------------------------------
// cctb_pkg
// Shared types and constants for the cycle counter time base.
// ----------------------------------------------------------------------------
package cctb_pkg;

  typedef logic [31:0] sample_t;
  typedef logic [63:0] total_t;
  typedef logic [9:0]  mhz_t;

  localparam int unsigned MICROS_PER_SEC = 1000000;
  localparam int unsigned THOUSAND       = 1000;

  localparam mhz_t CLOCK_MHZ_RESET = 10'd168;

  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned NUM_REGS = 1;

  localparam logic REG_CLOCK_MHZ = 1'b0;

  localparam int unsigned PER_S_W  = 30;
  localparam int unsigned SEC_W    = 45;
  localparam int unsigned PART_W   = 10;

endpackage

>>> rtl/cctb_front.sv
// ----------------------------------------------------------------------------
// cctb_front
// Accepts counter samples, tracks wraps and forms the 64-bit cycle total.
// ----------------------------------------------------------------------------
module cctb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cctb_pkg::sample_t counter_sample,
  output logic             push_valid,
  input  logic             push_ready,
  output cctb_pkg::total_t push_total
);
  import cctb_pkg::*;

  sample_t wrap_count;
  sample_t wrap_count_next;
  sample_t previous_sample;
  logic    accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    wrap_count_next = wrap_count;
    if (counter_sample < previous_sample) begin
      wrap_count_next = wrap_count + 32'd1;
    end
  end

  assign push_total = {wrap_count_next, counter_sample};

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_count      <= '0;
      previous_sample <= '0;
    end else if (accept) begin
      wrap_count      <= wrap_count_next;
      previous_sample <= counter_sample;
    end
  end

endmodule

>>> rtl/cctb_queue.sv
// ----------------------------------------------------------------------------
// cctb_queue
// Small first-in first-out queue of cycle totals between front and back.
// ----------------------------------------------------------------------------
module cctb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  cctb_pkg::total_t push_total,
  output logic             pop_valid,
  input  logic             pop_ready,
  output cctb_pkg::total_t pop_total
);
  import cctb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  total_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_total  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/cctb_div.sv
// ----------------------------------------------------------------------------
// cctb_div
// Iterative conversion of a cycle total into seconds, milliseconds,
// microseconds and a microsecond timeline, with an output register.
// ----------------------------------------------------------------------------
module cctb_div (
  input  logic                   clk,
  input  logic                   rst,
  input  cctb_pkg::mhz_t         mhz_eff,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  cctb_pkg::total_t       pop_total,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cctb_pkg::total_t       total_cycles,
  output logic [44:0]            whole_seconds,
  output logic [9:0]             millis_part,
  output logic [9:0]             micros_part,
  output cctb_pkg::total_t       timeline_micros
);
  import cctb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEC  = 3'd1;
  localparam logic [2:0] S_MS   = 3'd2;
  localparam logic [2:0] S_US   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [5:0] SEC_LAST  = 6'd63;
  localparam logic [5:0] PART_LAST = 6'(PART_W - 1);

  logic [2:0]         state;
  logic [5:0]         cnt;
  total_t             total_q;
  total_t             qa;
  logic [PER_S_W-1:0] ra;
  total_t             qb;
  mhz_t               rb;
  mhz_t               mhz;
  logic [PER_S_W-1:0] per_s;
  logic [PER_S_W-1:0] r2;
  logic [PER_S_W-1:0] dsh;
  logic [PART_W-1:0]  q2;
  logic [PART_W-1:0]  ms_q;

  logic [PER_S_W:0]   ta;
  logic [PER_S_W-1:0] ra_next;
  logic               qa_bit;
  logic [PART_W:0]    tb;
  mhz_t               rb_next;
  logic               qb_bit;
  logic               r2_ge;
  logic [PER_S_W-1:0] r2_next;
  logic [PART_W-1:0]  q2_next;
  logic [PER_S_W-1:0] per_s_calc;
  logic [PER_S_W-1:0] per_ms_sh;
  logic [PER_S_W-1:0] mhz_sh;
  logic               out_free;

  assign ta      = {ra, qa[63]};
  assign qa_bit  = (ta >= {1'b0, per_s});
  assign ra_next = qa_bit ? PER_S_W'(ta - {1'b0, per_s}) : ta[PER_S_W-1:0];

  assign tb      = {rb, qb[63]};
  assign qb_bit  = (tb >= {1'b0, mhz});
  assign rb_next = qb_bit ? PART_W'(tb - {1'b0, mhz}) : tb[PART_W-1:0];

  assign r2_ge   = (r2 >= dsh);
  assign r2_next = r2_ge ? r2 - dsh : r2;
  assign q2_next = {q2[PART_W-2:0], r2_ge};

  assign per_s_calc = PER_S_W'(32'(mhz_eff) * MICROS_PER_SEC);
  assign per_ms_sh  = PER_S_W'((32'(mhz) * THOUSAND) << (PART_W - 1));
  assign mhz_sh     = PER_S_W'(32'(mhz) << (PART_W - 1));

  assign pop_ready = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            state <= S_SEC;
            cnt   <= '0;
          end
        end
        S_SEC: begin
          if (cnt == SEC_LAST) begin
            state <= S_MS;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_MS: begin
          if (cnt == PART_LAST) begin
            state <= S_US;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_US: begin
          if (cnt == PART_LAST) begin
            state <= S_DONE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        total_q <= pop_total;
        qa      <= pop_total;
        qb      <= pop_total;
        ra      <= '0;
        rb      <= '0;
        mhz     <= mhz_eff;
        per_s   <= per_s_calc;
      end
      S_SEC: begin
        qa <= {qa[62:0], qa_bit};
        ra <= ra_next;
        qb <= {qb[62:0], qb_bit};
        rb <= rb_next;
        if (cnt == SEC_LAST) begin
          r2  <= ra_next;
          dsh <= per_ms_sh;
          q2  <= '0;
        end
      end
      S_MS: begin
        r2 <= r2_next;
        if (cnt == PART_LAST) begin
          ms_q <= q2_next;
          q2   <= '0;
          dsh  <= mhz_sh;
        end else begin
          q2  <= q2_next;
          dsh <= dsh >> 1;
        end
      end
      S_US: begin
        r2  <= r2_next;
        q2  <= q2_next;
        dsh <= dsh >> 1;
      end
      S_DONE: begin
        if (out_free) begin
          total_cycles    <= total_q;
          whole_seconds   <= qa[SEC_W-1:0];
          millis_part     <= ms_q;
          micros_part     <= q2;
          timeline_micros <= qb;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/cycle_counter_timebase.sv
// ----------------------------------------------------------------------------
// cycle_counter_timebase
// Extends 32-bit cycle counter samples to 64 bits and converts them to time.
//
// Each item on the input channel (in_valid/in_ready) is one sample of a
// free-running 32-bit cycle counter. A sample smaller than the one before
// counts one wrap. Each item yields one item on the output channel
// (out_valid/out_ready): the 64-bit cycle total, whole seconds, milliseconds
// within the second, microseconds within the millisecond and the
// microsecond timeline. The clock rate in MHz is set through the APB port
// at byte address 0 and the user is to write it only while the block is
// idle; the block itself does not enforce this. The front forms the total
// combinationally and queues it. The back divides it one quotient bit per
// cycle: first by the clock in Hz (alongside the timeline division by the
// clock in MHz), then for milliseconds and then for microseconds. It takes
// a new total only when it is done with the last one. The output register
// holds a result while the receiver stalls; the back then waits, and the
// queue keeps taking samples until it is full. Reset clears the wrap count,
// the previous sample and the queue, and sets the clock rate to 168 MHz.
// ----------------------------------------------------------------------------
module cycle_counter_timebase #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cctb_pkg::PADDR_W-1:0]   paddr,
  input  logic [cctb_pkg::PDATA_W-1:0]   pwdata,
  output logic [cctb_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    counter_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [63:0]                    total_cycles,
  output logic [44:0]                    whole_seconds,
  output logic [9:0]                     millis_part,
  output logic [9:0]                     micros_part,
  output logic [63:0]                    timeline_micros
);
  import cctb_pkg::*;

  mhz_t   clock_mhz;
  mhz_t   mhz_eff;
  logic   reg_sel;
  logic   push_valid;
  logic   push_ready;
  total_t push_total;
  logic   pop_valid;
  logic   pop_ready;
  total_t pop_total;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_CLOCK_MHZ);
  assign prdata  = reg_sel ? PDATA_W'(clock_mhz) : '0;
  assign mhz_eff = (clock_mhz == '0) ? 10'd1 : clock_mhz;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_mhz <= CLOCK_MHZ_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      clock_mhz <= pwdata[9:0];
    end
  end

  cctb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .counter_sample (counter_sample),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_total     (push_total)
  );

  cctb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_total (push_total),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_total  (pop_total)
  );

  cctb_div u_div (
    .clk             (clk),
    .rst             (rst),
    .mhz_eff         (mhz_eff),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_total       (pop_total),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .total_cycles    (total_cycles),
    .whole_seconds   (whole_seconds),
    .millis_part     (millis_part),
    .micros_part     (micros_part),
    .timeline_micros (timeline_micros)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cycle counter time base.
//
// Counter samples go in over a valid/ready channel and the clock rate is set
// over the APB port while the block is idle. The bench keeps its own wrap
// count and clock rate and works out the cycle total, seconds, milliseconds,
// microseconds and timeline for every accepted item. Each result that leaves
// the block is compared field by field with the oldest expected one. Directed
// items cover field extremes, equal samples, wraps and clock extremes; random
// items follow a running counter with jumps, under several idling mixes and
// one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import cctb_pkg::*;

  localparam int HOLD_OFF_CYCLES  = 600;
  localparam int QUIET_LIMIT      = 20000;
  localparam int SETTLE_CYCLES    = 100;
  localparam int RANDOM_PER_PHASE = 455;
  localparam int REG_OUT_OF_RANGE = 1;
  localparam int MAX_PRINTED      = 40;

  typedef struct {
    total_t        total;
    logic [44:0]   seconds;
    logic [9:0]    millis;
    logic [9:0]    micros;
    logic [63:0]   timeline;
  } timebase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t counter_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] total_cycles;
  logic [44:0] whole_seconds;
  logic [9:0] millis_part;
  logic [9:0] micros_part;
  logic [63:0] timeline_micros;

  timebase_t pending_times[$];
  mhz_t clock_shadow = CLOCK_MHZ_RESET;
  logic [31:0] wrap_tally = '0;
  sample_t prev_sample = '0;

  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  cycle_counter_timebase uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .counter_sample(counter_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .total_cycles(total_cycles),
    .whole_seconds(whole_seconds),
    .millis_part(millis_part),
    .micros_part(micros_part),
    .timeline_micros(timeline_micros)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  function automatic void predict_timebase(input sample_t s);
    logic [63:0] mhz, per_sec, per_ms, secs, rem_sec, ms, rem_ms, us;
    timebase_t t;
    if (s < prev_sample) begin
      wrap_tally = wrap_tally + 1;
    end
    prev_sample = s;
    mhz = (clock_shadow == '0) ? 64'd1 : {54'd0, clock_shadow};
    per_sec = mhz * 64'(MICROS_PER_SEC);
    per_ms = mhz * 64'(THOUSAND);
    t.total = {wrap_tally, s};
    secs = t.total / per_sec;
    rem_sec = t.total % per_sec;
    ms = rem_sec / per_ms;
    rem_ms = rem_sec % per_ms;
    us = rem_ms / mhz;
    t.seconds = secs[44:0];
    t.millis = ms[9:0];
    t.micros = us[9:0];
    t.timeline = secs * 64'(MICROS_PER_SEC) + ms * 64'(THOUSAND) + us;
    pending_times.push_back(t);
  endfunction

  task automatic check_result();
    timebase_t t;
    if (pending_times.size() == 0) begin
      report_mismatch("unexpected result, total_cycles", total_cycles, 64'd0);
    end else begin
      t = pending_times.pop_front();
      results_checked++;
      if (total_cycles !== t.total)
        report_mismatch("total_cycles", total_cycles, t.total);
      if (whole_seconds !== t.seconds)
        report_mismatch("whole_seconds", 64'(whole_seconds), 64'(t.seconds));
      if (millis_part !== t.millis)
        report_mismatch("millis_part", 64'(millis_part), 64'(t.millis));
      if (micros_part !== t.micros)
        report_mismatch("micros_part", 64'(micros_part), 64'(t.micros));
      if (timeline_micros !== t.timeline)
        report_mismatch("timeline_micros", timeline_micros, t.timeline);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      check_result();
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles with no item moving.", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    counter_sample <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_timebase(s);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * index);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == int'(REG_CLOCK_MHZ)) begin
      clock_shadow = value[9:0];
    end
  endtask

  task automatic write_clock(input mhz_t mhz);
    logic [31:0] noise;
    noise = $urandom() & ~32'h3FF;
    write_reg(int'(REG_CLOCK_MHZ), noise | {22'd0, mhz});
  endtask

  function automatic sample_t next_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return prev_sample + $urandom_range(2000000);
    if (pick < 70) return $urandom();
    if (pick < 80) return prev_sample;
    if (pick < 90) return 32'hFFFF_FFFF - $urandom_range(5000);
    return $urandom_range(5000);
  endfunction

  task automatic test_directed_samples();
    sample_t picks[13];
    picks = '{32'd0, 32'd0, 32'd1, 32'd167_999_999, 32'd168_000_000,
              32'd168_167_999, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (picks[i]) send_sample(picks[i]);
    drain_results();
  endtask

  task automatic test_clock_extremes();
    mhz_t clocks[4];
    clocks = '{10'd0, 10'd1, 10'd1023, 10'd1000};
    foreach (clocks[i]) begin
      write_clock(clocks[i]);
      send_sample(32'hFFFF_FFFF);
      send_sample($urandom());
      send_sample($urandom());
      drain_results();
    end
  endtask

  task automatic test_unmapped_write();
    write_reg(REG_OUT_OF_RANGE, 32'd5);
    send_sample($urandom());
    drain_results();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    repeat (10) send_sample(next_sample());
    drain_results();
  endtask

  task automatic test_random_phases();
    int send_mix[4];
    int stall_mix[4];
    mhz_t clocks[4];
    send_mix = '{0, 57, 0, 13};
    stall_mix = '{0, 0, 57, 13};
    clocks = '{10'd1023, 10'd1, mhz_t'($urandom_range(2, 1022)),
               mhz_t'($urandom_range(2, 1022))};
    foreach (send_mix[p]) begin
      write_clock(clocks[p]);
      send_idle_pct = send_mix[p];
      stall_pct = stall_mix[p];
      repeat (RANDOM_PER_PHASE) send_sample(next_sample());
      drain_results();
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_samples();
    test_clock_extremes();
    test_unmapped_write();
    test_output_backpressure();
    test_random_phases();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_times.size() != 0) begin
      report_mismatch("results still missing", 64'(pending_times.size()), 64'd0);
    end
    $display("Sent %0d samples and checked %0d results; the wrap count reached %0d.",
             items_sent, results_checked, wrap_tally);
    $display("Clock rates included 0, 1, 1000 and 1023 MHz, with idle, stall and hold-off.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> cycle_counter_timebase.f
rtl/cctb_pkg.sv
rtl/cctb_front.sv
rtl/cctb_queue.sv
rtl/cctb_div.sv
rtl/cycle_counter_timebase.sv
bench/tb.sv
